FILE: src/play_clock_button_control_top_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the player control RTL.
// ---------------------------------------------------------------------------
`ifndef PLAY_CLOCK_BUTTON_CONTROL_TOP_ASSERT_SVH
`define PLAY_CLOCK_BUTTON_CONTROL_TOP_ASSERT_SVH

// Checked on every edge once reset is released.
`define PCBC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define PCBC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: src/pcbc_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pcbc_pkg
// Types, codes and the seven-segment table of the player control unit.
// ---------------------------------------------------------------------------
package pcbc_pkg;

    localparam int RATE_W    = 18;
    localparam int ELAPSED_W = 13;   // 0 .. 5999 seconds
    localparam int POS_W     = 33;
    localparam int SEG_W     = 28;

    localparam logic [RATE_W-1:0]    SAMPLE_RATE_RST = 18'd48000;
    localparam logic [ELAPSED_W-1:0] ELAPSED_LAST    = 13'd5999;

    localparam logic KIND_TICK = 1'b0;

    typedef enum logic [1:0] {
        ST_READY   = 2'd0,
        ST_PLAYING = 2'd1,
        ST_PAUSED  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        HOST_IDLE  = 3'd0,
        HOST_PLAY  = 3'd1,
        HOST_PAUSE = 3'd2,
        HOST_SKIP  = 3'd4,
        HOST_BACK  = 3'd5
    } t_cmd;

    // Outcome of one item, handed from the control unit to the pipeline.
    typedef struct packed {
        logic [SEG_W-1:0]     seg;
        logic                 playing;
        t_status              status;
        t_cmd                 cmd;
        logic [31:0]          heartbeat;
        logic                 link_err;
        logic                 tick;
        logic [ELAPSED_W-1:0] elapsed;
    } t_ctrl_res;

    // Active-low segment pattern of one decimal digit.
    function automatic logic [6:0] seg_digit(input logic [3:0] d);
        logic [6:0] p;
        case (d)
            4'd0:    p = 7'h40;
            4'd1:    p = 7'h79;
            4'd2:    p = 7'h24;
            4'd3:    p = 7'h30;
            4'd4:    p = 7'h19;
            4'd5:    p = 7'h12;
            4'd6:    p = 7'h02;
            4'd7:    p = 7'h78;
            4'd8:    p = 7'h00;
            4'd9:    p = 7'h10;
            default: p = 7'h7F;
        endcase
        return p;
    endfunction

endpackage

FILE: src/play_clock_button_control_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// play_clock_button_control_top
// Player control unit: key and tick beats in, display and status beats out.
// ---------------------------------------------------------------------------
// An accepted beat passes the input, state and output stage in order; one beat
// per cycle unless the output is stalled. Three register stages; the byte
// position multiply (13 x 18 bits) sits between state and output stage.
// Reset (synchronous, active low) empties the pipeline, clears the player state
// and loads a sample rate of 48000; no clearing pass, ready on the next cycle.
// ---------------------------------------------------------------------------
module play_clock_button_control_top
    import pcbc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [RATE_W-1:0] i_cfg_sample_rate,
    // input beats
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_kind,
    input  logic [2:0]        i_keys_sampled,
    input  logic              i_host_linked,
    // result beats
    output logic              o_valid,
    input  logic              i_stall,
    output logic [SEG_W-1:0]  o_segment_word,
    output logic              o_playing,
    output logic [1:0]        o_player_status,
    output logic [2:0]        o_host_command,
    output logic [31:0]       o_heartbeat,
    output logic [POS_W-1:0]  o_byte_position,
    output logic              o_link_lost_flag
);

    logic              r_rate;
    logic [RATE_W-1:0] r_sample_rate;

    logic       r_s1_valid;
    logic       r_s1_kind;
    logic [2:0] r_s1_keys;
    logic       r_s1_linked;
    logic       r_s2_valid;
    t_ctrl_res  r_s2;
    logic       r_s3_valid;
    t_ctrl_res  r_s3;
    logic [POS_W-1:0] r_position;

    logic       s1_move, s2_move, s1_load;
    t_ctrl_res  ctrl_res;
    logic [ELAPSED_W+RATE_W-1:0] frames;

    assign s2_move = r_s2_valid && (!r_s3_valid || !i_stall);
    assign s1_move = r_s1_valid && (!r_s2_valid || s2_move);
    assign o_stall = r_s1_valid && !s1_move;
    assign s1_load = i_valid && !o_stall;

    assign o_cfg_ready = r_rate;
    assign frames      = (ELAPSED_W+RATE_W)'(r_s2.elapsed) *
                         (ELAPSED_W+RATE_W)'(r_sample_rate);

    pcbc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (s1_move),
        .i_kind   (r_s1_kind),
        .i_keys   (r_s1_keys),
        .i_linked (r_s1_linked),
        .o_res    (ctrl_res)
    );

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate        <= 1'b0;
            r_sample_rate <= SAMPLE_RATE_RST;
        end else begin
            r_rate <= 1'b1;
            if (i_cfg_valid && r_rate) begin
                r_sample_rate <= i_cfg_sample_rate;
            end
        end
    end

    // pipeline valids and byte position state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_position <= '0;
        end else begin
            if (s1_load) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_s2_valid <= 1'b1;
            end else if (s2_move) begin
                r_s2_valid <= 1'b0;
            end
            if (s2_move) begin
                r_s3_valid <= 1'b1;
            end else if (!i_stall) begin
                r_s3_valid <= 1'b0;
            end
            // four bytes per frame
            if (s2_move && r_s2.tick) begin
                r_position <= {frames, 2'b00};
            end
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1_kind   <= i_kind;
            r_s1_keys   <= i_keys_sampled;
            r_s1_linked <= i_host_linked;
        end
        if (s1_move) begin
            r_s2 <= ctrl_res;
        end
        if (s2_move) begin
            r_s3 <= r_s2;
        end
    end

    assign o_valid          = r_s3_valid;
    assign o_segment_word   = r_s3.seg;
    assign o_playing        = r_s3.playing;
    assign o_player_status  = r_s3.status;
    assign o_host_command   = r_s3.cmd;
    assign o_heartbeat      = r_s3.heartbeat;
    assign o_byte_position  = r_position;
    assign o_link_lost_flag = r_s3.link_err;

`include "play_clock_button_control_top_assert.svh"

    `PCBC_ASSERT(a_stall_needs_item, o_stall |-> r_s1_valid && r_s2_valid, "input stalled with room in the pipeline")
    `PCBC_ASSERT(a_held_result_kept, r_s3_valid && i_stall |=> r_s3_valid && $stable(r_position), "waiting result lost or changed")
    `PCBC_ASSERT(a_position_only_on_tick, s2_move && !r_s2.tick |=> $stable(r_position), "byte position moved on a key beat")
    `PCBC_ASSERT_ALWAYS(a_reset_empties, !i_rst_n |=> !r_s1_valid && !r_s2_valid && !r_s3_valid, "pipeline not empty after reset")

endmodule

FILE: src/pcbc_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// pcbc_ctrl
// Player state: link handling, key edges, play clock and heartbeat.
// ---------------------------------------------------------------------------
module pcbc_ctrl
    import pcbc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  logic      i_kind,
    input  logic [2:0] i_keys,
    input  logic      i_linked,
    output t_ctrl_res o_res
);

    logic                 r_run, n_run;
    logic                 r_half, n_half;
    logic [3:0]           r_sec_ones, n_sec_ones;
    logic [2:0]           r_sec_tens, n_sec_tens;
    logic [3:0]           r_min_ones, n_min_ones;
    logic [3:0]           r_min_tens, n_min_tens;
    logic [ELAPSED_W-1:0] r_elapsed, n_elapsed;
    logic [2:0]           r_prev_keys, n_prev_keys;
    logic                 r_prev_link, n_prev_link;
    t_status              r_status, n_status;
    logic [31:0]          r_ticks, n_ticks;
    logic                 r_link_err, n_link_err;
    t_cmd                 cmd;
    logic [2:0]           fell;
    logic [ELAPSED_W-1:0] clock_secs;

    always_comb begin
        n_run       = r_run;
        n_half      = r_half;
        n_sec_ones  = r_sec_ones;
        n_sec_tens  = r_sec_tens;
        n_min_ones  = r_min_ones;
        n_min_tens  = r_min_tens;
        n_elapsed   = r_elapsed;
        n_prev_keys = r_prev_keys;
        n_prev_link = r_prev_link;
        n_status    = r_status;
        n_ticks     = r_ticks;
        n_link_err  = r_link_err;
        cmd         = HOST_IDLE;
        fell        = ~i_keys & r_prev_keys;

        // link change goes first
        if (i_linked != r_prev_link) begin
            if (i_linked) begin
                n_half     = 1'b0;
                n_sec_ones = '0;
                n_sec_tens = '0;
                n_min_ones = '0;
                n_min_tens = '0;
                n_elapsed  = '0;
                n_link_err = 1'b0;
            end else begin
                n_run      = 1'b0;
                n_status   = ST_READY;
                n_link_err = 1'b1;
            end
            n_prev_link = i_linked;
        end

        if (i_kind == KIND_TICK) begin
            n_ticks = r_ticks + 32'd1;
            if (n_run && i_linked) begin
                if (!n_half) begin
                    n_half = 1'b1;
                end else begin
                    n_half    = 1'b0;
                    n_elapsed = (n_elapsed == ELAPSED_LAST) ? '0
                                                            : n_elapsed + ELAPSED_W'(1);
                    if (n_sec_ones != 4'd9) begin
                        n_sec_ones = n_sec_ones + 4'd1;
                    end else begin
                        n_sec_ones = '0;
                        if (n_sec_tens != 3'd5) begin
                            n_sec_tens = n_sec_tens + 3'd1;
                        end else begin
                            n_sec_tens = '0;
                            if (n_min_ones != 4'd9) begin
                                n_min_ones = n_min_ones + 4'd1;
                            end else begin
                                n_min_ones = '0;
                                n_min_tens = (n_min_tens == 4'd9) ? '0 : n_min_tens + 4'd1;
                            end
                        end
                    end
                end
            end
        end else begin
            if (i_linked) begin
                if (fell[0]) begin
                    if (n_run) begin
                        n_run    = 1'b0;
                        n_status = ST_PAUSED;
                        cmd      = HOST_PAUSE;
                    end else begin
                        n_run    = 1'b1;
                        n_status = ST_PLAYING;
                        cmd      = HOST_PLAY;
                    end
                end
                // next, then previous: the later key wins
                if (fell[1]) begin
                    cmd = HOST_SKIP;
                end
                if (fell[2]) begin
                    cmd = HOST_BACK;
                end
                if (fell[1] || fell[2]) begin
                    n_half     = 1'b0;
                    n_sec_ones = '0;
                    n_sec_tens = '0;
                    n_min_ones = '0;
                    n_min_tens = '0;
                    n_elapsed  = '0;
                end
            end
            // taken even when the press is refused
            n_prev_keys = i_keys;
        end

        o_res.seg       = {seg_digit(n_min_tens), seg_digit(n_min_ones),
                           seg_digit({1'b0, n_sec_tens}), seg_digit(n_sec_ones)};
        o_res.playing   = n_run;
        o_res.status    = n_status;
        o_res.cmd       = cmd;
        o_res.heartbeat = n_ticks;
        o_res.link_err  = n_link_err;
        o_res.tick      = (i_kind == KIND_TICK);
        o_res.elapsed   = n_elapsed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run       <= 1'b0;
            r_half      <= 1'b0;
            r_sec_ones  <= '0;
            r_sec_tens  <= '0;
            r_min_ones  <= '0;
            r_min_tens  <= '0;
            r_elapsed   <= '0;
            r_prev_keys <= 3'b111;
            r_prev_link <= 1'b0;
            r_status    <= ST_READY;
            r_ticks     <= '0;
            r_link_err  <= 1'b0;
        end else if (i_step) begin
            r_run       <= n_run;
            r_half      <= n_half;
            r_sec_ones  <= n_sec_ones;
            r_sec_tens  <= n_sec_tens;
            r_min_ones  <= n_min_ones;
            r_min_tens  <= n_min_tens;
            r_elapsed   <= n_elapsed;
            r_prev_keys <= n_prev_keys;
            r_prev_link <= n_prev_link;
            r_status    <= n_status;
            r_ticks     <= n_ticks;
            r_link_err  <= n_link_err;
        end
    end

    // seconds shown by the digits, for cross-checking the running count
    assign clock_secs = ELAPSED_W'(r_min_tens) * ELAPSED_W'(600)
                      + ELAPSED_W'(r_min_ones) * ELAPSED_W'(60)
                      + ELAPSED_W'(r_sec_tens) * ELAPSED_W'(10)
                      + ELAPSED_W'(r_sec_ones);

`include "play_clock_button_control_top_assert.svh"

    `PCBC_ASSERT(a_run_matches_status, r_run == (r_status == ST_PLAYING), "run flag and status disagree")
    `PCBC_ASSERT(a_elapsed_matches_digits, r_elapsed == clock_secs, "elapsed out of step with digits")
    `PCBC_ASSERT(a_no_run_after_link_loss, r_link_err |-> !r_run && !r_prev_link, "playing while link is lost")

endmodule

FILE: tb/tb_play_clock_button_control_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_play_clock_button_control_top
// Self-checking bench for the player control unit. A directed table walks
// link changes, every key and the refused presses. A play run then carries
// the mm:ss clock past its first minute. Random tick and key beats follow
// under several sample rates. Each result is checked field by field against its
// table row or an in-bench model; both sides idle at random in most phases.
// ---------------------------------------------------------------------------
module tb_play_clock_button_control_top;
    import pcbc_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int LONG_TICKS  = 130;   // a little over one minute of playing
    localparam int PHASE_BEATS = 250;
    localparam int N_PHASES    = 6;
    localparam int PRINT_CAP   = 200;

    localparam logic KIND_KEYS = 1'b1;

    // active-low key samples
    localparam logic [2:0] KEYS_UP     = 3'b111;
    localparam logic [2:0] KEY_PLAY_DN = 3'b110;
    localparam logic [2:0] KEY_NEXT_DN = 3'b101;
    localparam logic [2:0] KEY_PREV_DN = 3'b011;
    localparam logic [2:0] KEYS_ALL_DN = 3'b000;

    // digit d occupies bits 7*d+6 : 7*d
    localparam logic [69:0] DIGIT_SEGS = {7'h10, 7'h00, 7'h78, 7'h02, 7'h12,
                                          7'h19, 7'h30, 7'h24, 7'h79, 7'h40};
    localparam logic [SEG_W-1:0] SEG_ZERO = {4{7'h40}};
    localparam logic [SEG_W-1:0] SEG_0001 = {7'h40, 7'h40, 7'h40, 7'h79};

    typedef struct packed {
        logic [SEG_W-1:0] seg;
        logic             playing;
        t_status          status;
        t_cmd             cmd;
        logic [31:0]      heartbeat;
        logic [POS_W-1:0] pos;
        logic             lost;
    } t_player_out;

    typedef struct packed {
        logic        kind;
        logic [2:0]  keys;
        logic        link;
        logic        typed;   // row carries its own result
        t_player_out want;
    } t_row;

    typedef struct {
        logic             run;
        logic             half;
        logic [5:0]       sec;
        logic [6:0]       min;
        logic [2:0]       keys_seen;
        logic             link_seen;
        t_status          status;
        logic [31:0]      ticks;
        logic [POS_W-1:0] pos;
        logic             lost;
    } t_player_state;

    localparam t_player_out UNTYPED = '0;
    localparam int N_DIR = 23;
    localparam t_row DIR_TAB [0:N_DIR-1] = '{
        // tick and refused press before any link
        '{KIND_TICK, KEYS_UP,     1'b0, 1'b1,
          '{SEG_ZERO, 1'b0, ST_READY,   HOST_IDLE,  32'd1, 33'd0, 1'b0}},
        '{KIND_KEYS, KEY_PLAY_DN, 1'b0, 1'b1,
          '{SEG_ZERO, 1'b0, ST_READY,   HOST_IDLE,  32'd1, 33'd0, 1'b0}},
        '{KIND_KEYS, KEYS_UP,     1'b1, 1'b1,
          '{SEG_ZERO, 1'b0, ST_READY,   HOST_IDLE,  32'd1, 33'd0, 1'b0}},
        '{KIND_KEYS, KEY_PLAY_DN, 1'b1, 1'b1,
          '{SEG_ZERO, 1'b1, ST_PLAYING, HOST_PLAY,  32'd1, 33'd0, 1'b0}},
        // keys on a tick leave the stored sample alone
        '{KIND_TICK, KEYS_ALL_DN, 1'b1, 1'b1,
          '{SEG_ZERO, 1'b1, ST_PLAYING, HOST_IDLE,  32'd2, 33'd0, 1'b0}},
        '{KIND_TICK, 3'b101,      1'b1, 1'b1,
          '{SEG_0001, 1'b1, ST_PLAYING, HOST_IDLE,  32'd3, 33'd192000, 1'b0}},
        '{KIND_KEYS, KEYS_UP,     1'b1, 1'b0, UNTYPED},
        '{KIND_KEYS, KEY_PLAY_DN, 1'b1, 1'b1,
          '{SEG_0001, 1'b0, ST_PAUSED,  HOST_PAUSE, 32'd3, 33'd192000, 1'b0}},
        '{KIND_TICK, KEY_PLAY_DN, 1'b1, 1'b0, UNTYPED},
        '{KIND_KEYS, 3'b100,      1'b1, 1'b0, UNTYPED},
        '{KIND_KEYS, KEYS_UP,     1'b1, 1'b0, UNTYPED},
        // all three fall together: previous wins
        '{KIND_KEYS, KEYS_ALL_DN, 1'b1, 1'b0, UNTYPED},
        '{KIND_KEYS, 3'b011,      1'b1, 1'b0, UNTYPED},
        '{KIND_KEYS, KEYS_UP,     1'b1, 1'b0, UNTYPED},
        '{KIND_KEYS, KEY_PREV_DN, 1'b1, 1'b0, UNTYPED},
        '{KIND_TICK, KEYS_UP,     1'b1, 1'b0, UNTYPED},
        // link lost on a tick
        '{KIND_TICK, KEYS_UP,     1'b0, 1'b1,
          '{SEG_ZERO, 1'b0, ST_READY,   HOST_IDLE,  32'd6, 33'd0, 1'b1}},
        '{KIND_KEYS, KEY_PLAY_DN, 1'b0, 1'b0, UNTYPED},
        '{KIND_KEYS, KEYS_UP,     1'b0, 1'b0, UNTYPED},
        '{KIND_KEYS, KEY_PLAY_DN, 1'b1, 1'b0, UNTYPED},
        '{KIND_KEYS, KEYS_UP,     1'b0, 1'b0, UNTYPED},
        '{KIND_KEYS, KEYS_UP,     1'b1, 1'b0, UNTYPED},
        '{KIND_TICK, KEYS_UP,     1'b1, 1'b0, UNTYPED}
    };

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [RATE_W-1:0] i_cfg_sample_rate = '0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic              i_kind = KIND_TICK;
    logic [2:0]        i_keys_sampled = KEYS_UP;
    logic              i_host_linked = 1'b0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [SEG_W-1:0]  o_segment_word;
    logic              o_playing;
    logic [1:0]        o_player_status;
    logic [2:0]        o_host_command;
    logic [31:0]       o_heartbeat;
    logic [POS_W-1:0]  o_byte_position;
    logic              o_link_lost_flag;

    play_clock_button_control_top dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_sample_rate (i_cfg_sample_rate),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_kind            (i_kind),
        .i_keys_sampled    (i_keys_sampled),
        .i_host_linked     (i_host_linked),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_segment_word    (o_segment_word),
        .o_playing         (o_playing),
        .o_player_status   (o_player_status),
        .o_host_command    (o_host_command),
        .o_heartbeat       (o_heartbeat),
        .o_byte_position   (o_byte_position),
        .o_link_lost_flag  (o_link_lost_flag)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_player_state     player;
    logic [RATE_W-1:0] rate_now = SAMPLE_RATE_RST;
    t_player_out       results_due [$];
    logic              row_typed = 1'b0;
    t_player_out       row_want = '0;
    bit                tx_idling = 1'b1;
    bit                rx_idling = 1'b1;
    int                mismatches = 0;
    int                results_seen = 0;
    int                beats_sent = 0;
    int                rate_writes = 0;
    int                cycles = 0;
    int                rx_left = 0;

    // ---------------------------------------------------------------- model
    function automatic void clear_clock();
        player.half = 1'b0;
        player.sec  = '0;
        player.min  = '0;
    endfunction

    function automatic logic [SEG_W-1:0] clock_segments(input int mm, input int ss);
        return {DIGIT_SEGS[(mm / 10) * 7 +: 7], DIGIT_SEGS[(mm % 10) * 7 +: 7],
                DIGIT_SEGS[(ss / 10) * 7 +: 7], DIGIT_SEGS[(ss % 10) * 7 +: 7]};
    endfunction

    function automatic t_player_out step_player(input logic kind, input logic [2:0] keys,
                                                input logic link);
        logic [2:0]      fell;
        longint unsigned bytes;
        t_cmd            cmd;
        t_player_out     r;
        cmd = HOST_IDLE;
        if (link != player.link_seen) begin
            if (link) begin
                clear_clock();
                player.lost = 1'b0;
            end else begin
                player.run    = 1'b0;
                player.status = ST_READY;
                player.lost   = 1'b1;
            end
            player.link_seen = link;
        end
        if (kind == KIND_TICK) begin
            player.ticks = player.ticks + 32'd1;
            if (player.run && link) begin
                if (!player.half) begin
                    player.half = 1'b1;
                end else begin
                    player.half = 1'b0;
                    if (player.sec == 6'd59) begin
                        player.sec = '0;
                        player.min = (player.min == 7'd99) ? 7'd0 : player.min + 7'd1;
                    end else begin
                        player.sec = player.sec + 6'd1;
                    end
                end
            end
            bytes = (longint'(player.min) * 60 + longint'(player.sec)) * longint'(rate_now) * 4;
            player.pos = bytes[POS_W-1:0];
        end else begin
            fell = ~keys & player.keys_seen;
            if (link) begin
                if (fell[0]) begin
                    player.run    = !player.run;
                    player.status = player.run ? ST_PLAYING : ST_PAUSED;
                    cmd           = player.run ? HOST_PLAY : HOST_PAUSE;
                end
                if (fell[1]) begin
                    cmd = HOST_SKIP;
                    clear_clock();
                end
                if (fell[2]) begin
                    cmd = HOST_BACK;
                    clear_clock();
                end
            end
            player.keys_seen = keys;
        end
        r.seg       = clock_segments(player.min, player.sec);
        r.playing   = player.run;
        r.status    = player.status;
        r.cmd       = cmd;
        r.heartbeat = player.ticks;
        r.pos       = player.pos;
        r.lost      = player.lost;
        return r;
    endfunction

    // ------------------------------------------------------------- checking
    task automatic report_miss(input string field, input logic [63:0] want,
                               input logic [63:0] got);
        mismatches++;
        if (mismatches <= PRINT_CAP)
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, field, want, got);
    endtask

    always @(posedge i_clk) begin : scoreboard
        t_player_out want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                results_seen++;
                if (results_due.size() == 0) begin
                    mismatches++;
                    $display("%0t ns: result beat with nothing outstanding, seg 0x%0h",
                             $time, o_segment_word);
                end else begin
                    want = results_due.pop_front();
                    if (o_segment_word !== want.seg)
                        report_miss("segment_word", want.seg, o_segment_word);
                    if (o_playing !== want.playing)
                        report_miss("playing", want.playing, o_playing);
                    if (o_player_status !== want.status)
                        report_miss("player_status", want.status, o_player_status);
                    if (o_host_command !== want.cmd)
                        report_miss("host_command", want.cmd, o_host_command);
                    if (o_heartbeat !== want.heartbeat)
                        report_miss("heartbeat", want.heartbeat, o_heartbeat);
                    if (o_byte_position !== want.pos)
                        report_miss("byte_position", want.pos, o_byte_position);
                    if (o_link_lost_flag !== want.lost)
                        report_miss("link_lost_flag", want.lost, o_link_lost_flag);
                end
            end
            if (i_valid && !o_stall) begin
                want = step_player(i_kind, i_keys_sampled, i_host_linked);
                results_due.push_back(row_typed ? row_want : want);
            end
        end
    end

    // receiver stalls in random bursts
    always @(posedge i_clk) begin
        if (!i_rst_n || !rx_idling) begin
            i_stall <= 1'b0;
            rx_left <= 0;
        end else if (rx_left != 0) begin
            rx_left <= rx_left - 1;
        end else if (i_stall) begin
            i_stall <= 1'b0;
            rx_left <= $urandom_range(0, 40);
        end else if ($urandom_range(0, 3) == 0) begin
            i_stall <= 1'b1;
            rx_left <= $urandom_range(0, 15);
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles, %0d results outstanding",
                     cycles, results_due.size());
            $display("FAIL play_clock_button_control_top");
            $finish;
        end
    end

    // -------------------------------------------------------------- driving
    task automatic send_beat(input logic kind, input logic [2:0] keys, input logic link,
                             input logic typed, input t_player_out want);
        int gap;
        if (tx_idling && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 16);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_kind         <= kind;
        i_keys_sampled <= keys;
        i_host_linked  <= link;
        row_typed      <= typed;
        row_want       <= want;
        do @(posedge i_clk); while (o_stall);
        beats_sent++;
    endtask

    // idle the input and let every outstanding result come back
    task automatic settle(input int extra);
        i_valid <= 1'b0;
        // the beat taken at this edge is queued by the scoreboard by the next one
        @(posedge i_clk);
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic load_rate(input logic [RATE_W-1:0] rate);
        i_cfg_valid       <= 1'b1;
        i_cfg_sample_rate <= rate;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        rate_now = rate;
        rate_writes++;
    endtask

    initial begin
        logic              kind_pick;
        logic [2:0]        keys_pick;
        logic              link_pick;
        logic [RATE_W-1:0] rate_pick;
        int                pick;
        player = '{run: 1'b0, half: 1'b0, sec: '0, min: '0, keys_seen: KEYS_UP,
                   link_seen: 1'b0, status: ST_READY, ticks: '0, pos: '0, lost: 1'b0};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < N_DIR; r++)
            send_beat(DIR_TAB[r].kind, DIR_TAB[r].keys, DIR_TAB[r].link,
                      DIR_TAB[r].typed, DIR_TAB[r].want);

        // play run: drop and restore the link, start playing, tick past 01:00
        settle(4);
        load_rate(18'd192000);
        send_beat(KIND_KEYS, KEYS_UP, 1'b0, 1'b0, UNTYPED);
        send_beat(KIND_KEYS, KEYS_UP, 1'b1, 1'b0, UNTYPED);
        send_beat(KIND_KEYS, KEY_PLAY_DN, 1'b1, 1'b0, UNTYPED);
        send_beat(KIND_KEYS, KEYS_UP, 1'b1, 1'b0, UNTYPED);
        for (int n = 0; n < LONG_TICKS; n++)
            send_beat(KIND_TICK, 3'($urandom()), 1'b1, 1'b0, UNTYPED);

        link_pick = 1'b1;
        for (int ph = 0; ph < N_PHASES; ph++) begin
            settle(4);
            case (ph)
                0:       rate_pick = 18'd8000;
                1:       rate_pick = '1;
                2:       rate_pick = '0;
                3:       rate_pick = RATE_W'($urandom());
                4:       rate_pick = RATE_W'($urandom_range(8000, 192000));
                default: rate_pick = 18'd44100;
            endcase
            load_rate(rate_pick);
            tx_idling = (ph != 2) && (ph != N_PHASES - 1);
            rx_idling = (ph != N_PHASES - 1);
            for (int n = 0; n < PHASE_BEATS; n++) begin
                if ($urandom_range(0, 99) < 3)
                    link_pick = !link_pick;
                kind_pick = ($urandom_range(0, 99) < 55) ? KIND_TICK : KIND_KEYS;
                pick = $urandom_range(0, 9);
                if (pick < 4)
                    keys_pick = KEYS_UP;
                else if (pick < 6)
                    keys_pick = KEY_PLAY_DN;
                else if (pick == 6)
                    keys_pick = KEY_NEXT_DN;
                else if (pick == 7)
                    keys_pick = KEY_PREV_DN;
                else
                    keys_pick = 3'($urandom_range(0, 7));
                send_beat(kind_pick, keys_pick, link_pick, 1'b0, UNTYPED);
            end
        end

        settle(10);
        $display("Sent %0d beats (%0d ticks in the minute-carry run), checked %0d results,",
                 beats_sent, LONG_TICKS, results_seen);
        $display("over %0d sample-rate writes; %0d field mismatches", rate_writes, mismatches);
        if (mismatches == 0)
            $display("PASS play_clock_button_control_top");
        else
            $display("FAIL play_clock_button_control_top");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+src
src/pcbc_pkg.sv
src/pcbc_ctrl.sv
src/play_clock_button_control_top.sv
tb/tb_play_clock_button_control_top.sv
